### src/i2cms_pkg.sv
`timescale 1ns / 1ps
package i2cms_pkg;

	localparam int COUNT_WIDTH_DEF = 16;
	localparam int PLEN_W = 16;
	localparam int ACKCNT_W = 16;
	localparam logic [15:0] PLEN_RESET = 16'd100;

	localparam logic [1:0] OP_NONE = 2'd0;
	localparam logic [1:0] OP_REG_READ = 2'd1;
	localparam logic [1:0] OP_REG_WRITE = 2'd2;
	localparam logic [1:0] OP_BURST = 2'd3;

	localparam logic [2:0] STAT_OK = 3'd0;
	localparam logic [2:0] STAT_WADDR_NACK = 3'd1;
	localparam logic [2:0] STAT_REG_NACK = 3'd2;
	localparam logic [2:0] STAT_RADDR_NACK = 3'd3;
	localparam logic [2:0] STAT_FINAL_NACK = 3'd4;

	localparam logic [1:0] CFG_PHASE_LENGTH = 2'd0;
	localparam logic [1:0] CFG_WRITE_ADDR = 2'd1;
	localparam logic [1:0] CFG_READ_ADDR = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_WADDR,
		ST_ACK_WADDR,
		ST_REG,
		ST_ACK_REG,
		ST_RSTART,
		ST_RADDR,
		ST_ACK_RADDR,
		ST_RDATA,
		ST_NACK,
		ST_DATA,
		ST_ACK_DATA,
		ST_STOP
	} step_t;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] register_address;
		logic [7:0] write_data;
		logic       data_last;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic [15:0] phase_length;
		logic [6:0]  write_device_address;
		logic [6:0]  read_device_address;
	} cfg_t;

	typedef struct packed {
		logic [15:0] acked_count;
		logic [2:0]  status;
		logic [7:0]  rx_data;
		logic        byte_taken;
		logic        done_res;
		logic        busy_res;
		logic        sda_drive;
		logic        sda_out;
		logic        scl_out;
	} res_t;

	// levels as {SCL, SDA, drive}
	function automatic logic [2:0] unit_levels(step_t s, logic [1:0] pi, logic b);
		logic [2:0] lv;
		case (s)
			ST_START: begin
				case (pi)
					2'd0: lv = 3'b111;
					2'd1: lv = 3'b101;
					2'd2: lv = 3'b101;
					default: lv = 3'b001;
				endcase
			end
			ST_RSTART: begin
				case (pi)
					2'd0: lv = 3'b011;
					2'd1: lv = 3'b111;
					2'd2: lv = 3'b101;
					default: lv = 3'b001;
				endcase
			end
			ST_STOP: begin
				case (pi)
					2'd0: lv = 3'b001;
					2'd1: lv = 3'b101;
					2'd2: lv = 3'b101;
					default: lv = 3'b111;
				endcase
			end
			ST_ACK_WADDR, ST_ACK_REG, ST_ACK_RADDR, ST_ACK_DATA: begin
				case (pi)
					2'd0: lv = 3'b010;
					2'd1: lv = 3'b110;
					2'd2: lv = 3'b110;
					default: lv = 3'b001;
				endcase
			end
			ST_RDATA: begin
				case (pi)
					2'd1: lv = 3'b110;
					2'd2: lv = 3'b110;
					default: lv = 3'b010;
				endcase
			end
			ST_IDLE: lv = 3'b111;
			default: lv = {(pi == 2'd1) || (pi == 2'd2), b, 1'b1};
		endcase
		return lv;
	endfunction

endpackage

### src/i2cms_cfg.sv
`timescale 1ns / 1ps
module i2cms_cfg (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_data,
	output i2cms_pkg::cfg_t      cfg
);

	i2cms_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_length <= i2cms_pkg::PLEN_RESET;
			cfg_q.write_device_address <= 7'd0;
			cfg_q.read_device_address <= 7'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				i2cms_pkg::CFG_PHASE_LENGTH: cfg_q.phase_length <= cfg_data;
				i2cms_pkg::CFG_WRITE_ADDR: cfg_q.write_device_address <= cfg_data[6:0];
				i2cms_pkg::CFG_READ_ADDR: cfg_q.read_device_address <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### src/i2cms_core.sv
`timescale 1ns / 1ps
module i2cms_core #(
	parameter int COUNT_WIDTH = i2cms_pkg::COUNT_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  i2cms_pkg::item_t     item,
	input  i2cms_pkg::cfg_t      cfg,
	output i2cms_pkg::res_t      res
);

	localparam int ACK_W = (COUNT_WIDTH < i2cms_pkg::ACKCNT_W) ? COUNT_WIDTH
		: i2cms_pkg::ACKCNT_W;
	localparam logic [ACK_W-1:0] ACK_LIMIT = {ACK_W{1'b1}};

	i2cms_pkg::step_t step_q, step_n, s;
	logic [15:0]      pc_q, pc_n, pc_e, plen;
	logic [1:0]       pi_q, pi_n, pi_e;
	logic [2:0]       bc_q, bc_n, bc_e;
	logic [7:0]       shift_q, shift_n;
	logic [7:0]       recv_q, recv_n;
	logic [1:0]       pend_q, pend_n;
	logic [7:0]       latch_q, latch_n;
	logic             final_q, final_n;
	logic [2:0]       stat_q, stat_n;
	logic [ACK_W-1:0] ack_q, ack_n;
	logic             samp_q, samp_n;
	logic             start, load, last_tick, acked, rd, taken, done, busy;
	logic [2:0]       lv;
	logic [16:0]      pc_inc;

	always_comb begin
		start = (step_q == i2cms_pkg::ST_IDLE) && (item.operation != i2cms_pkg::OP_NONE);
		s = start ? i2cms_pkg::ST_START : step_q;
		pc_e = start ? 16'd0 : pc_q;
		pi_e = start ? 2'd0 : pi_q;
		bc_e = start ? 3'd0 : bc_q;
		samp_n = start ? 1'b1 : samp_q;
		stat_n = start ? i2cms_pkg::STAT_OK : stat_q;
		ack_n = start ? '0 : ack_q;
		final_n = start ? 1'b0 : final_q;
		pend_n = start ? item.operation : pend_q;
		latch_n = start ? item.register_address : latch_q;
		plen = (cfg.phase_length == 16'd0) ? 16'd1 : cfg.phase_length;
		pc_inc = {1'b0, pc_e} + 17'd1;
		last_tick = pc_inc >= {1'b0, plen};
		shift_n = shift_q;
		recv_n = recv_q;
		step_n = s;
		pc_n = pc_e;
		pi_n = pi_e;
		bc_n = bc_e;
		taken = 1'b0;
		done = 1'b0;
		busy = (s != i2cms_pkg::ST_IDLE);
		rd = (pend_n == i2cms_pkg::OP_REG_READ);
		lv = 3'b111;
		acked = 1'b0;
		load = 1'b0;
		if (busy) begin
			load = ((s == i2cms_pkg::ST_WADDR) || (s == i2cms_pkg::ST_REG)
				|| (s == i2cms_pkg::ST_RADDR) || (s == i2cms_pkg::ST_DATA))
				&& (bc_e == 3'd0) && (pi_e == 2'd0) && (pc_e == 16'd0);
			if (load) begin
				case (s)
					i2cms_pkg::ST_WADDR: shift_n = {cfg.write_device_address, 1'b0};
					i2cms_pkg::ST_REG: shift_n = latch_n;
					i2cms_pkg::ST_RADDR: shift_n = {cfg.read_device_address, 1'b1};
					default: begin
						shift_n = item.write_data;
						final_n = item.data_last;
						taken = 1'b1;
					end
				endcase
			end
			lv = i2cms_pkg::unit_levels(s, pi_e,
				(s == i2cms_pkg::ST_NACK) ? 1'b1 : shift_n[3'd7 - bc_e]);
			if (last_tick && (pi_e == 2'd1)) begin
				if (s == i2cms_pkg::ST_RDATA)
					shift_n = {shift_n[6:0], item.sda_in};
				else if (!lv[0])
					samp_n = item.sda_in;
			end
			acked = !samp_n;
			if (!last_tick) begin
				pc_n = pc_inc[15:0];
			end else begin
				pc_n = 16'd0;
				if (pi_e != 2'd3) begin
					pi_n = pi_e + 2'd1;
				end else begin
					pi_n = 2'd0;
					bc_n = 3'd0;
					case (s)
						i2cms_pkg::ST_START: step_n = i2cms_pkg::ST_WADDR;
						i2cms_pkg::ST_RSTART: step_n = i2cms_pkg::ST_RADDR;
						i2cms_pkg::ST_WADDR, i2cms_pkg::ST_REG,
						i2cms_pkg::ST_RADDR, i2cms_pkg::ST_DATA: begin
							if (bc_e == 3'd7)
								step_n = i2cms_pkg::step_t'(s + 4'd1);
							else
								bc_n = bc_e + 3'd1;
						end
						i2cms_pkg::ST_ACK_WADDR: begin
							if (rd && !acked) begin
								stat_n = i2cms_pkg::STAT_WADDR_NACK;
								step_n = i2cms_pkg::ST_STOP;
							end else begin
								step_n = (pend_n == i2cms_pkg::OP_BURST)
									? i2cms_pkg::ST_DATA : i2cms_pkg::ST_REG;
							end
						end
						i2cms_pkg::ST_ACK_REG: begin
							if (rd && !acked) begin
								stat_n = i2cms_pkg::STAT_REG_NACK;
								step_n = i2cms_pkg::ST_STOP;
							end else begin
								step_n = rd ? i2cms_pkg::ST_RSTART : i2cms_pkg::ST_DATA;
							end
						end
						i2cms_pkg::ST_ACK_RADDR: begin
							if (!acked) begin
								stat_n = i2cms_pkg::STAT_RADDR_NACK;
								step_n = i2cms_pkg::ST_STOP;
							end else begin
								shift_n = 8'd0;
								step_n = i2cms_pkg::ST_RDATA;
							end
						end
						i2cms_pkg::ST_RDATA: begin
							if (bc_e == 3'd7) begin
								recv_n = shift_n;
								step_n = i2cms_pkg::ST_NACK;
							end else begin
								bc_n = bc_e + 3'd1;
							end
						end
						i2cms_pkg::ST_NACK: step_n = i2cms_pkg::ST_STOP;
						i2cms_pkg::ST_ACK_DATA: begin
							if (pend_n == i2cms_pkg::OP_BURST) begin
								if (acked && (ack_n < ACK_LIMIT))
									ack_n = ack_n + ACK_W'(1);
								if (final_n) begin
									stat_n = acked ? i2cms_pkg::STAT_OK
										: i2cms_pkg::STAT_FINAL_NACK;
									step_n = i2cms_pkg::ST_STOP;
								end else begin
									step_n = i2cms_pkg::ST_DATA;
								end
							end else begin
								stat_n = acked ? i2cms_pkg::STAT_OK
									: i2cms_pkg::STAT_FINAL_NACK;
								step_n = i2cms_pkg::ST_STOP;
							end
						end
						i2cms_pkg::ST_STOP: begin
							step_n = i2cms_pkg::ST_IDLE;
							done = 1'b1;
						end
						default: step_n = i2cms_pkg::ST_IDLE;
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= i2cms_pkg::ST_IDLE;
			pc_q <= 16'd0;
			pi_q <= 2'd0;
			bc_q <= 3'd0;
			shift_q <= 8'd0;
			recv_q <= 8'd0;
			pend_q <= i2cms_pkg::OP_NONE;
			latch_q <= 8'd0;
			final_q <= 1'b0;
			stat_q <= i2cms_pkg::STAT_OK;
			ack_q <= '0;
			samp_q <= 1'b1;
		end else if (en) begin
			step_q <= step_n;
			pc_q <= pc_n;
			pi_q <= pi_n;
			bc_q <= bc_n;
			shift_q <= shift_n;
			recv_q <= recv_n;
			pend_q <= pend_n;
			latch_q <= latch_n;
			final_q <= final_n;
			stat_q <= stat_n;
			ack_q <= ack_n;
			samp_q <= samp_n;
		end
	end

	always_comb begin
		res.scl_out = lv[2];
		res.sda_out = lv[1];
		res.sda_drive = lv[0];
		res.busy_res = busy;
		res.done_res = done;
		res.byte_taken = taken;
		res.rx_data = recv_n;
		res.status = stat_n;
		res.acked_count = i2cms_pkg::ACKCNT_W'(ack_n);
	end

endmodule

### src/i2c_master_sequencer_top.sv
`timescale 1ns / 1ps
// I2C master sequencer: each input transfer is one bus tick and yields exactly one output
// transfer with the SCL/SDA levels for that tick plus transaction status. Items are taken
// one per clock when the output side keeps up; the work sits between an input register
// and an output register; a result is registered when its item leaves the input stage.
// Every bus unit is four phases of phase_length ticks (zero counts as one). Configuration
// writes take effect at once and are to be made while no transaction is running.
module i2c_master_sequencer_top #(
	parameter int COUNT_WIDTH = i2cms_pkg::COUNT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// register_address[7:0], write_data[15:8], sda_in[16], zero [23:17]
	input  logic [23:0] s_tdata,
	input  logic        s_tlast,   // data_last
	input  logic [1:0]  s_tuser,   // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	// scl_out[0], sda_out[1], sda_drive[2], busy_res[3], done_res[4], byte_taken[5],
	// rx_data[13:6], status[16:14], acked_count[32:17], zero [39:33]
	output logic [39:0] m_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	i2cms_pkg::item_t item_s1;
	logic             valid_s1;
	i2cms_pkg::res_t  res, res_s2;
	logic             valid_s2;
	i2cms_pkg::cfg_t  cfg;
	logic             adv;

	assign adv = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.operation <= s_tuser;
			item_s1.register_address <= s_tdata[7:0];
			item_s1.write_data <= s_tdata[15:8];
			item_s1.data_last <= s_tlast;
			item_s1.sda_in <= s_tdata[16];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	i2cms_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	i2cms_core #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata = {7'd0, res_s2};

endmodule

### src/i2cms_checker.sv
`timescale 1ns / 1ps
module i2cms_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output valid dropped before transfer");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("output data changed while stalled");

	a_idle_lines: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[3] |-> m_tdata[2:0] == 3'b111 && !m_tdata[4] && !m_tdata[5])
		else $error("idle tick with bus lines not released high");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4] |-> m_tdata[3] && m_tdata[2:0] == 3'b111)
		else $error("done outside a stop end");

	a_release_high: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[2] |-> m_tdata[1])
		else $error("sda_out low while released");

endmodule

bind i2c_master_sequencer_top i2cms_checker u_i2cms_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

### verif/i2c_master_sequencer_top_tb.sv
`timescale 1ns / 1ps
module i2c_master_sequencer_top_tb;
	import i2cms_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam logic [15:0] ACK_CEIL = (COUNT_WIDTH_DEF >= 16) ? 16'hFFFF :
		16'((32'd1 << COUNT_WIDTH_DEF) - 1);

	// levels {SCL, SDA, drive} per phase, phase 0 in the lowest bits
	localparam logic [11:0] LV_START = {3'b001, 3'b101, 3'b101, 3'b111};
	localparam logic [11:0] LV_RSTART = {3'b001, 3'b101, 3'b111, 3'b011};
	localparam logic [11:0] LV_ACK = {3'b001, 3'b110, 3'b110, 3'b010};
	localparam logic [11:0] LV_READ = {3'b010, 3'b110, 3'b110, 3'b010};
	localparam logic [11:0] LV_STOP = {3'b111, 3'b101, 3'b101, 3'b001};

	typedef struct {
		step_t       step;
		logic [15:0] pcnt;
		logic [1:0]  pidx;
		logic [3:0]  bitc;
		logic [7:0]  shreg;
		logic [7:0]  rxbyte;
		logic [1:0]  op;
		logic [7:0]  regl;
		logic        fin;
		logic [2:0]  stat;
		logic [15:0] acks;
		logic        samp;
	} seq_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic [1:0]  s_tuser = OP_NONE;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_PHASE_LENGTH;
	logic [15:0] cfg_data = '0;

	seq_state_t gen_seq;
	seq_state_t mirror_seq;
	cfg_t       cfg_now;
	item_t      tick_q[$];
	res_t       line_state_q[$];
	item_t      held_item;
	int         ticks_made = 0;
	int         errors = 0;
	int         cycles = 0;
	logic       steady = 1'b0;

	i2c_master_sequencer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic seq_state_t seq_reset();
		seq_state_t st;
		st.step = ST_IDLE;
		st.pcnt = '0;
		st.pidx = '0;
		st.bitc = '0;
		st.shreg = '0;
		st.rxbyte = '0;
		st.op = OP_NONE;
		st.regl = '0;
		st.fin = 1'b0;
		st.stat = STAT_OK;
		st.acks = '0;
		st.samp = 1'b1;
		return st;
	endfunction

	function automatic res_t step_sequencer(inout seq_state_t st, input cfg_t c, input item_t it);
		res_t r;
		logic [2:0] lv;
		logic [16:0] plen;
		logic bitv, last_tick, acked, rd, jump;
		step_t nx;
		r = '0;
		if (st.step == ST_IDLE && it.operation != OP_NONE) begin
			st.op = it.operation;
			st.regl = it.register_address;
			st.stat = STAT_OK;
			st.acks = '0;
			st.fin = 1'b0;
			st.pcnt = '0;
			st.pidx = '0;
			st.samp = 1'b1;
			st.step = ST_START;
			st.bitc = '0;
		end
		if (st.step == ST_IDLE) begin
			lv = 3'b111;
		end else begin
			r.busy_res = 1'b1;
			if ((st.step inside {ST_WADDR, ST_REG, ST_RADDR, ST_DATA}) && st.bitc == 0 &&
					st.pidx == 0 && st.pcnt == 0) begin
				case (st.step)
					ST_WADDR: st.shreg = {c.write_device_address, 1'b0};
					ST_REG: st.shreg = st.regl;
					ST_RADDR: st.shreg = {c.read_device_address, 1'b1};
					default: begin
						st.shreg = it.write_data;
						st.fin = it.data_last;
						r.byte_taken = 1'b1;
					end
				endcase
			end
			bitv = (st.step == ST_NACK) ? 1'b1 : st.shreg[3'd7 - st.bitc[2:0]];
			case (st.step)
				ST_START: lv = LV_START[st.pidx * 3 +: 3];
				ST_RSTART: lv = LV_RSTART[st.pidx * 3 +: 3];
				ST_STOP: lv = LV_STOP[st.pidx * 3 +: 3];
				ST_ACK_WADDR, ST_ACK_REG, ST_ACK_RADDR, ST_ACK_DATA: lv = LV_ACK[st.pidx * 3 +: 3];
				ST_RDATA: lv = LV_READ[st.pidx * 3 +: 3];
				default: lv = {(st.pidx == 2'd1 || st.pidx == 2'd2), bitv, 1'b1};
			endcase
			if (!lv[0])
				lv[1] = 1'b1;
			plen = (c.phase_length == 0) ? 17'd1 : {1'b0, c.phase_length};
			last_tick = ({1'b0, st.pcnt} + 17'd1) >= plen;
			if (last_tick && st.pidx == 2'd1) begin
				if (st.step == ST_RDATA)
					st.shreg = {st.shreg[6:0], it.sda_in};
				else if (lv == 3'b110 || !lv[0])
					st.samp = it.sda_in;
			end
			if (!last_tick) begin
				st.pcnt = st.pcnt + 16'd1;
			end else begin
				st.pcnt = '0;
				if (st.pidx != 2'd3) begin
					st.pidx = st.pidx + 2'd1;
				end else begin
					st.pidx = '0;
					acked = !st.samp;
					rd = st.op == OP_REG_READ;
					jump = 1'b1;
					nx = st.step;
					case (st.step)
						ST_START: nx = ST_WADDR;
						ST_RSTART: nx = ST_RADDR;
						ST_WADDR, ST_REG, ST_RADDR, ST_DATA, ST_RDATA: begin
							if (st.bitc >= 4'd7) begin
								if (st.step == ST_RDATA)
									st.rxbyte = st.shreg;
								nx = step_t'(st.step + 1);
							end else begin
								st.bitc = st.bitc + 4'd1;
								jump = 1'b0;
							end
						end
						ST_ACK_WADDR: begin
							if (rd && !acked) begin
								st.stat = STAT_WADDR_NACK;
								nx = ST_STOP;
							end else begin
								nx = (st.op == OP_BURST) ? ST_DATA : ST_REG;
							end
						end
						ST_ACK_REG: begin
							if (rd && !acked) begin
								st.stat = STAT_REG_NACK;
								nx = ST_STOP;
							end else begin
								nx = rd ? ST_RSTART : ST_DATA;
							end
						end
						ST_ACK_RADDR: begin
							if (!acked) begin
								st.stat = STAT_RADDR_NACK;
								nx = ST_STOP;
							end else begin
								st.shreg = '0;
								nx = ST_RDATA;
							end
						end
						ST_NACK: nx = ST_STOP;
						ST_ACK_DATA: begin
							if (st.op == OP_BURST) begin
								if (acked && st.acks < ACK_CEIL)
									st.acks = st.acks + 16'd1;
								if (st.fin) begin
									st.stat = acked ? STAT_OK : STAT_FINAL_NACK;
									nx = ST_STOP;
								end else begin
									nx = ST_DATA;
								end
							end else begin
								st.stat = acked ? STAT_OK : STAT_FINAL_NACK;
								nx = ST_STOP;
							end
						end
						ST_STOP: begin
							nx = ST_IDLE;
							r.done_res = 1'b1;
						end
						default: nx = ST_IDLE;
					endcase
					if (jump) begin
						st.step = nx;
						st.bitc = '0;
					end
				end
			end
		end
		r.scl_out = lv[2];
		r.sda_out = lv[1];
		r.sda_drive = lv[0];
		r.rx_data = st.rxbyte;
		r.status = st.stat;
		r.acked_count = st.acks;
		return r;
	endfunction

	task automatic push_tick(input item_t it);
		void'(step_sequencer(gen_seq, cfg_now, it));
		tick_q.push_back(it);
		ticks_made++;
	endtask

	task automatic idle_ticks(input int n);
		item_t it;
		repeat (n) begin
			it.operation = OP_NONE;
			it.register_address = 8'($urandom);
			it.write_data = 8'($urandom);
			it.data_last = 1'($urandom);
			it.sda_in = 1'($urandom);
			push_tick(it);
		end
	endtask

	// nack_on names the acknowledge step that always sees a NACK; ST_IDLE means none
	task automatic run_txn(input logic [1:0] op, input logic [7:0] ra, input step_t nack_on,
			input int nack_pct, input int nbytes);
		item_t it;
		int sent;
		logic first;
		sent = 0;
		first = 1'b1;
		do begin
			it.operation = first ? op : 2'($urandom_range(3));
			it.register_address = first ? ra : 8'($urandom);
			it.write_data = 8'($urandom);
			it.data_last = 1'($urandom);
			if (gen_seq.step inside {ST_ACK_WADDR, ST_ACK_REG, ST_ACK_RADDR, ST_ACK_DATA})
				it.sda_in = (gen_seq.step == nack_on) || ($urandom_range(99) < nack_pct);
			else
				it.sda_in = 1'($urandom);
			if (gen_seq.step == ST_DATA && gen_seq.bitc == 0 && gen_seq.pidx == 0 &&
					gen_seq.pcnt == 0) begin
				sent++;
				it.data_last = sent >= nbytes;
			end
			push_tick(it);
			first = 1'b0;
		end while (gen_seq.step != ST_IDLE);
	endtask

	task automatic random_phase(input int target);
		int base;
		base = ticks_made;
		while (ticks_made - base < target) begin
			if ($urandom_range(99) < 80)
				run_txn(2'($urandom_range(1, 3)), 8'($urandom), ST_IDLE, 8, $urandom_range(1, 4));
			else
				run_txn(2'($urandom_range(3)), 8'($urandom), ST_IDLE, 50, $urandom_range(1, 3));
			idle_ticks($urandom_range(0, 2));
		end
	endtask

	task automatic drain();
		while (tick_q.size() != 0 || s_tvalid || line_state_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_PHASE_LENGTH: cfg_now.phase_length = val;
			CFG_WRITE_ADDR: cfg_now.write_device_address = val[6:0];
			default: cfg_now.read_device_address = val[6:0];
		endcase
	endtask

	task automatic compare_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			$display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic check_levels(input logic [39:0] data);
		res_t want, got;
		got = data[32:0];
		if (line_state_q.size() == 0) begin
			$display("%0t result with nothing expected: expected none actual %h", $time, data);
			errors++;
		end else begin
			want = line_state_q.pop_front();
			compare_field("scl_out", want.scl_out, got.scl_out);
			compare_field("sda_out", want.sda_out, got.sda_out);
			compare_field("sda_drive", want.sda_drive, got.sda_drive);
			compare_field("busy_res", want.busy_res, got.busy_res);
			compare_field("done_res", want.done_res, got.done_res);
			compare_field("byte_taken", want.byte_taken, got.byte_taken);
			compare_field("rx_data", want.rx_data, got.rx_data);
			compare_field("status", want.status, got.status);
			compare_field("acked_count", want.acked_count, got.acked_count);
			compare_field("padding", '0, data[39:33]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
			s_tuser <= OP_NONE;
		end else begin
			if (s_tvalid && s_tready)
				line_state_q.push_back(step_sequencer(mirror_seq, cfg_now, held_item));
			if (!s_tvalid || s_tready) begin
				if (tick_q.size() != 0 && (steady || $urandom_range(99) >= 23)) begin
					held_item = tick_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {7'd0, held_item.sda_in, held_item.write_data,
						held_item.register_address};
					s_tlast <= held_item.data_last;
					s_tuser <= held_item.operation;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				check_levels(m_tdata);
			m_tready <= steady || ($urandom_range(99) >= 23);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		gen_seq = seq_reset();
		mirror_seq = seq_reset();
		cfg_now.phase_length = PLEN_RESET;
		cfg_now.write_device_address = '0;
		cfg_now.read_device_address = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset phase length is too long for a whole transaction
		idle_ticks(8);
		drain();

		// zero phase length counts as one
		write_reg(CFG_PHASE_LENGTH, 16'd0);
		write_reg(CFG_WRITE_ADDR, 16'h007F);
		write_reg(CFG_READ_ADDR, 16'h0000);
		run_txn(OP_REG_READ, 8'hFF, ST_IDLE, 0, 1);
		run_txn(OP_REG_READ, 8'h00, ST_ACK_WADDR, 0, 1);
		run_txn(OP_REG_READ, 8'h5A, ST_ACK_REG, 0, 1);
		run_txn(OP_REG_READ, 8'hA5, ST_ACK_RADDR, 0, 1);
		run_txn(OP_REG_WRITE, 8'hFF, ST_ACK_DATA, 0, 1);
		run_txn(OP_BURST, 8'h00, ST_IDLE, 0, 3);
		run_txn(OP_BURST, 8'hFF, ST_ACK_DATA, 0, 2);
		run_txn(OP_BURST, 8'h81, ST_ACK_WADDR, 0, 1);
		idle_ticks(3);
		drain();

		steady = 1'b1;
		write_reg(CFG_PHASE_LENGTH, 16'd2);
		write_reg(CFG_WRITE_ADDR, 16'($urandom_range(127)));
		write_reg(CFG_READ_ADDR, 16'($urandom_range(127)));
		random_phase(150);
		drain();
		steady = 1'b0;

		write_reg(CFG_PHASE_LENGTH, 16'hFFFF);
		idle_ticks(10);
		drain();
		repeat (8) @(posedge clk);

		if (errors == 0 && line_state_q.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
